// File: rtl/multichannel_moving_average_top_assert.svh
// ----------------------------------------------------------------------------
// multichannel moving average assertion macros
// Shared property macros for the moving average checker. Each macro expects
// signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Types, constants and helpers shared by the moving average filter files.
// ----------------------------------------------------------------------------
package mma_pkg;

  // default sizing
  localparam int CHANNELS_DEF    = 7;
  localparam int CAM_DEPTH_DEF   = 16;
  localparam int FORCE_DEPTH_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_WINDOW     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSION_WINDOW = 1'b1;
  localparam logic [CFG_DATA_W-1:0] CAM_WINDOW_RST     = 5'd8;
  localparam logic [CFG_DATA_W-1:0] TENSION_WINDOW_RST = 5'd8;

  // channel code that is never processed
  localparam logic [2:0] CHANNEL_INVALID = 3'd7;

  // input item
  typedef struct packed {
    logic [2:0]         channel;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [23:0] pull_force;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [31:0] avg_x;
    logic signed [31:0] avg_y;
    logic signed [23:0] avg_force;
  } out_item_t;

  // index width for n entries, at least one bit
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// File: rtl/mma_stream_if.sv
// ----------------------------------------------------------------------------
// mma_stream_if
// Valid/ready stream channel carrying one packed item per transfer.
// ----------------------------------------------------------------------------
interface mma_stream_if #(
  parameter type T = mma_pkg::in_item_t
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [mma_pkg::idx_bits(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [mma_pkg::idx_bits(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import mma_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mma_divider.sv
// ----------------------------------------------------------------------------
// mma_divider
// Radix-2 restoring divider, signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mma_divider #(
  parameter int DIVIDEND_W = 37,
  parameter int DIVISOR_W  = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);
  import mma_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  running;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] mag;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  fits;
  logic [DIVISOR_W:0]    rem_diff;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, mag[DIVIDEND_W-1]};
    fits     = rem_sh >= {1'b0, dsr};
    rem_diff = rem_sh - {1'b0, dsr};
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIVIDEND_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude register doubles as quotient register
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIVIDEND_W-1];
      mag <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      rem <= fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      mag <= {mag[DIVIDEND_W-2:0], fits};
    end
  end

  // restore the sign
  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

// File: rtl/multichannel_moving_average_top.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_top
// Per-channel sliding-window averager for camera x, camera y and tension.
// ----------------------------------------------------------------------------
// Each item carries a channel and three samples. Channel 7, or any channel at
// or above CHANNELS, is dropped with no result. Otherwise the samples go into
// that channel's ring buffers and one result item returns the three window
// means, truncated toward zero; samples never received count as zero and a
// window length of zero gives a zero mean and skips its division. The input
// is not ready from acceptance until the result is loaded, so the next item
// can be taken in the cycle after that; a result still waiting on the output
// holds the sequencer until it leaves. The one serial divider is shared by
// the three means at one quotient bit per cycle, and the summing pass reads
// one ring entry per cycle. No clearing pass follows reset: a per-channel
// fill count masks entries not yet written.
module multichannel_moving_average_top #(
  parameter int CHANNELS    = mma_pkg::CHANNELS_DEF,
  parameter int CAM_DEPTH   = mma_pkg::CAM_DEPTH_DEF,
  parameter int FORCE_DEPTH = mma_pkg::FORCE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data,
  mma_stream_if.sink                       in_item,
  mma_stream_if.source                     out_item
);
  import mma_pkg::*;

  localparam int MAX_DEPTH = (CAM_DEPTH > FORCE_DEPTH) ? CAM_DEPTH : FORCE_DEPTH;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CH_W      = idx_bits(CHANNELS);
  localparam int CSLOT_W   = idx_bits(CAM_DEPTH);
  localparam int FSLOT_W   = idx_bits(FORCE_DEPTH);
  localparam int CADDR_W   = idx_bits(CHANNELS * CAM_DEPTH);
  localparam int FADDR_W   = idx_bits(CHANNELS * FORCE_DEPTH);
  localparam int SUM_W     = 32 + CNT_W;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_WRITE     = 6'b000010,
    S_READ      = 6'b000100,
    S_DIV_START = 6'b001000,
    S_DIV_WAIT  = 6'b010000,
    S_OUT       = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_F = 2'd2
  } div_sel_t;

  state_t   state;
  div_sel_t div_sel;
  div_sel_t div_sel_next;

  logic [CFG_DATA_W-1:0] cam_window;
  logic [CFG_DATA_W-1:0] tension_window;

  logic [2:0]         ch_reg;
  logic signed [31:0] smp_x;
  logic signed [31:0] smp_y;
  logic signed [23:0] smp_f;

  logic [CSLOT_W-1:0] head_c [CHANNELS];
  logic [FSLOT_W-1:0] head_f [CHANNELS];
  logic [CNT_W-1:0]   fill   [CHANNELS];

  logic [CNT_W-1:0] age;
  logic             rd_pend;
  logic             rd_cam;
  logic             rd_frc;

  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_f;

  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [23:0] res_f;

  logic      out_valid;
  out_item_t out_data;

  logic [CH_W-1:0]    ch_idx;
  logic               in_ch_ok;
  logic               accept;
  logic [CNT_W-1:0]   ncam;
  logic [CNT_W-1:0]   nfrc;
  logic [CNT_W-1:0]   nmax;
  logic [CSLOT_W-1:0] head_c_new;
  logic [FSLOT_W-1:0] head_f_new;
  logic [CADDR_W-1:0] c_waddr;
  logic [CADDR_W-1:0] c_raddr;
  logic [FADDR_W-1:0] f_waddr;
  logic [FADDR_W-1:0] f_raddr;
  logic               issue;
  logic               cam_take;
  logic               frc_take;
  logic               ram_we;
  logic [31:0]        x_rdata;
  logic [31:0]        y_rdata;
  logic [23:0]        f_rdata;

  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0]        div_divisor;
  logic signed [SUM_W-1:0] div_quotient;
  logic signed [SUM_W-1:0] store_val;
  logic                    store_en;

  // handshake
  assign in_item.ready  = (state == S_IDLE);
  assign accept         = in_item.valid && in_item.ready;
  assign in_ch_ok       = (in_item.data.channel != CHANNEL_INVALID) &&
                          (int'(in_item.data.channel) < CHANNELS);
  assign out_item.valid = out_valid;
  assign out_item.data  = out_data;

  assign ch_idx = CH_W'(ch_reg);

  // effective window lengths, saturated at the ring depth
  always_comb begin
    ncam = (int'(cam_window) > CAM_DEPTH) ? CNT_W'(CAM_DEPTH) : CNT_W'(cam_window);
    nfrc = (int'(tension_window) > FORCE_DEPTH) ? CNT_W'(FORCE_DEPTH)
                                                : CNT_W'(tension_window);
    nmax = (ncam > nfrc) ? ncam : nfrc;
  end

  // ring write position: advance the head and store the newest sample there
  always_comb begin
    head_c_new = (head_c[ch_idx] == CSLOT_W'(CAM_DEPTH - 1)) ? '0 : head_c[ch_idx] + 1'b1;
    head_f_new = (head_f[ch_idx] == FSLOT_W'(FORCE_DEPTH - 1)) ? '0 : head_f[ch_idx] + 1'b1;
    c_waddr    = CADDR_W'(int'(ch_idx) * CAM_DEPTH + int'(head_c_new));
    f_waddr    = FADDR_W'(int'(ch_idx) * FORCE_DEPTH + int'(head_f_new));
  end

  // ring read position: age steps back from the newest sample
  always_comb begin
    int hc;
    int hf;
    int a;
    int cs;
    int fs;
    hc = int'(head_c[ch_idx]);
    hf = int'(head_f[ch_idx]);
    a  = int'(age);
    cs = (hc >= a) ? hc - a : hc + CAM_DEPTH - a;
    fs = (hf >= a) ? hf - a : hf + FORCE_DEPTH - a;
    c_raddr  = CADDR_W'(int'(ch_idx) * CAM_DEPTH + cs);
    f_raddr  = FADDR_W'(int'(ch_idx) * FORCE_DEPTH + fs);
    issue    = (state == S_READ) && (age < nmax);
    cam_take = (age < ncam) && (age < fill[ch_idx]);
    frc_take = (age < nfrc) && (age < fill[ch_idx]);
  end

  assign ram_we = (state == S_WRITE);

  // sample rings, all channels packed in one memory per field
  mma_ram #(.WIDTH(32), .DEPTH(CHANNELS * CAM_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_waddr),
    .wdata (smp_x),
    .raddr (c_raddr),
    .rdata (x_rdata)
  );

  mma_ram #(.WIDTH(32), .DEPTH(CHANNELS * CAM_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_waddr),
    .wdata (smp_y),
    .raddr (c_raddr),
    .rdata (y_rdata)
  );

  mma_ram #(.WIDTH(24), .DEPTH(CHANNELS * FORCE_DEPTH)) u_ram_f (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f_waddr),
    .wdata (smp_f),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // divider operand select and result capture
  always_comb begin
    unique case (div_sel)
      SEL_X: begin
        div_dividend = sum_x;
        div_divisor  = ncam;
        div_sel_next = SEL_Y;
      end
      SEL_Y: begin
        div_dividend = sum_y;
        div_divisor  = ncam;
        div_sel_next = SEL_F;
      end
      SEL_F: begin
        div_dividend = sum_f;
        div_divisor  = nfrc;
        div_sel_next = SEL_F;
      end
      default: begin
        div_dividend = sum_x;
        div_divisor  = ncam;
        div_sel_next = SEL_X;
      end
    endcase
    div_start = (state == S_DIV_START) && (div_divisor != '0);
    store_en  = ((state == S_DIV_START) && (div_divisor == '0)) ||
                ((state == S_DIV_WAIT) && div_done);
    store_val = (state == S_DIV_WAIT) ? div_quotient : '0;
  end

  mma_divider #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_window     <= CAM_WINDOW_RST;
      tension_window <= TENSION_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_WINDOW:     cam_window     <= cfg_data;
        REG_TENSION_WINDOW: tension_window <= cfg_data;
      endcase
    end
  end

  // sequencer and per-channel ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_sel   <= SEL_X;
      age       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        head_c[c] <= '0;
        head_f[c] <= '0;
        fill[c]   <= '0;
      end
    end else begin
      // result leaves; a new one is loaded only from the output state
      if (out_valid && out_item.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_ch_ok) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          head_c[ch_idx] <= head_c_new;
          head_f[ch_idx] <= head_f_new;
          if (fill[ch_idx] != CNT_W'(MAX_DEPTH)) begin
            fill[ch_idx] <= fill[ch_idx] + 1'b1;
          end
          age     <= '0;
          rd_pend <= 1'b0;
          state   <= S_READ;
        end
        S_READ: begin
          rd_pend <= issue;
          if (issue) begin
            age <= age + 1'b1;
          end else if (!rd_pend) begin
            div_sel <= SEL_X;
            state   <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          if (div_divisor != '0) begin
            state <= S_DIV_WAIT;
          end else if (div_sel == SEL_F) begin
            state <= S_OUT;
          end else begin
            div_sel <= div_sel_next;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (div_sel == SEL_F) begin
              state <= S_OUT;
            end else begin
              div_sel <= div_sel_next;
              state   <= S_DIV_START;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_item.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture, window sums, quotients and the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_reg <= in_item.data.channel;
      smp_x  <= in_item.data.x_pos;
      smp_y  <= in_item.data.y_pos;
      smp_f  <= in_item.data.pull_force;
    end
    if (state == S_WRITE) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_f <= '0;
    end else if (state == S_READ) begin
      rd_cam <= issue && cam_take;
      rd_frc <= issue && frc_take;
      if (rd_pend && rd_cam) begin
        sum_x <= sum_x + SUM_W'($signed(x_rdata));
        sum_y <= sum_y + SUM_W'($signed(y_rdata));
      end
      if (rd_pend && rd_frc) begin
        sum_f <= sum_f + SUM_W'($signed(f_rdata));
      end
    end
    if (store_en) begin
      unique case (div_sel)
        SEL_X:   res_x <= store_val[31:0];
        SEL_Y:   res_y <= store_val[31:0];
        SEL_F:   res_f <= store_val[23:0];
        default: res_f <= store_val[23:0];
      endcase
    end
    if ((state == S_OUT) && (!out_valid || out_item.ready)) begin
      out_data.out_channel <= ch_reg;
      out_data.avg_x       <= res_x;
      out_data.avg_y       <= res_y;
      out_data.avg_force   <= res_f;
    end
  end

endmodule

// File: rtl/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks for the moving average filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_top_assert.svh"

module mma_checker #(
  parameter int CHANNELS = mma_pkg::CHANNELS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_channel,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_channel,
  input logic [31:0] avg_x,
  input logic [31:0] avg_y,
  input logic [23:0] avg_force
);
  import mma_pkg::*;

  logic in_take_ok;

  // an item on a live channel is being taken
  assign in_take_ok = in_valid && in_ready && (in_channel != CHANNEL_INVALID) &&
                      (int'(in_channel) < CHANNELS);

  // a waiting result stays offered
  `MMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a waiting result keeps its payload
  `MMA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_channel) && $stable(avg_x) && $stable(avg_y) && $stable(avg_force), "result changed while stalled")

  // only live channels are ever reported
  `MMA_ASSERT_SAME(a_out_channel, out_valid, (out_channel != CHANNEL_INVALID) && (int'(out_channel) < CHANNELS), "result on a dropped channel")

  // a live item keeps the block busy for the next cycle
  `MMA_ASSERT_NEXT(a_busy_after_take, in_take_ok, !in_ready, "input ready right after a live item")

  // no result can appear in the cycle after any item is taken
  `MMA_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result appeared too early")

endmodule

bind multichannel_moving_average_top mma_checker #(.CHANNELS(CHANNELS)) u_mma_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .in_channel  (in_item.data.channel),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .out_channel (out_item.data.out_channel),
  .avg_x       (out_item.data.avg_x),
  .avg_y       (out_item.data.avg_y),
  .avg_force   (out_item.data.avg_force)
);
